// File: rtl/sle_pkg.sv
// Shared types and codes for the sequential list engine.
// No dependencies; compiled first.
`default_nettype none

package sle_pkg;

	// Request operation codes; code 7 is unused and answers with no change
	typedef enum logic [2:0] {
		MD_APPEND     = 3'd0,
		MD_PUSH_FRONT = 3'd1,
		MD_INSERT     = 3'd2,
		MD_POP_BACK   = 3'd3,
		MD_POP_FRONT  = 3'd4,
		MD_ERASE      = 3'd5,
		MD_FIND       = 3'd6
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	localparam int MODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 2;
	localparam int FOUND_W = 5;
	localparam int COUNT_W = 5;

	// Found index reported when there is no match
	localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

endpackage

`default_nettype wire

// File: rtl/sle_req_if.sv
// Request channel of the sequential list engine: valid/ready plus payload.
// Depends on sle_pkg for field widths.
`default_nettype none

interface sle_req_if;
	import sle_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/sle_rsp_if.sv
// Result channel of the sequential list engine: valid/ready plus payload.
// Depends on sle_pkg for field widths.
`default_nettype none

interface sle_rsp_if;
	import sle_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic signed [FOUND_W-1:0] found_index;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, output status, output found_index, output count, input ready);
	modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/sequential_list_engine.sv
// Sequential list engine: contiguous list in one synchronous memory.
// Depends on sle_pkg, sle_req_if and sle_rsp_if.
// Errors, mode 7 and a find on an empty list answer at once; append, pop back, push front into
// an empty list and erase of the last entry need no move; insert before p moves entries up from
// the tail, erase at p moves them down to the tail, find scans from the front; fronts act at p = 0.
// One request at a time, one word moved or compared per cycle; a held output register adds its
// wait, and the next request is taken the edge after the result enters it.
// Reset (arst_n low) empties the list at once; the entry memory itself is not cleared.
`default_nettype none

module sequential_list_engine #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);
	import sle_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DN,
		S_FIND,
		S_FIN,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           at_q;
	logic [DATA_WIDTH-1:0]   word_q;
	logic                    ins_q;
	logic                    wr_s1;
	logic                    cmp_s1;
	logic                    last_s1;
	logic [AW-1:0]           waddr_s1;
	logic [AW-1:0]           idx_s1;
	status_t                 res_status_q;
	logic [FOUND_W-1:0]      res_found_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [FOUND_W-1:0]      out_found_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic [DATA_WIDTH-1:0]   entries_q [CAPACITY];
	logic [DATA_WIDTH-1:0]   rd_data_q;

	logic [2*VALUE_W-1:0]    value_ext;
	logic [DATA_WIDTH-1:0]   word_in;
	logic                    full;
	logic                    empty;
	logic                    pos_bad;
	logic [AW-1:0]           last_idx;
	logic [AW-1:0]           pos_idx;
	logic                    match;
	logic                    rd_en;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [DATA_WIDTH-1:0]   mem_wdata;

	// Decode request and list status
	always_comb begin
		value_ext = {{VALUE_W{1'b0}}, req.value};
		word_in   = value_ext[DATA_WIDTH-1:0];
		full      = (cnt_q == CW'(CAPACITY));
		empty     = (cnt_q == '0);
		pos_bad   = (PW'(req.position) >= PW'(cnt_q));
		last_idx  = AW'(cnt_q - CW'(1));
		pos_idx   = AW'(req.position);
		match     = (rd_data_q == word_q);
	end

	// Drive the memory port: reads follow idx_q, writes retire the previous read or place the new word
	always_comb begin
		case (state_q)
			S_UP, S_DN: rd_en = 1'b1;
			S_FIND:     rd_en = !(cmp_s1 && (match || last_s1));
			default:    rd_en = 1'b0;
		endcase
		if (wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = rd_data_q;
		end else begin
			mem_we    = (state_q == S_FIN) && ins_q;
			mem_waddr = at_q;
			mem_wdata = word_q;
		end
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			entries_q[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= entries_q[idx_q];
	end

	// Sequence each request and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			wr_s1       <= 1'b0;
			cmp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1  <= 1'b0;
			cmp_s1 <= 1'b0;
			if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						word_q       <= word_in;
						res_found_q  <= FOUND_NONE;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
						case (req.mode)
							MD_APPEND, MD_PUSH_FRONT, MD_INSERT: begin
								ins_q <= 1'b1;
								if (full) begin
									res_status_q <= ST_FULL;
								end else if (req.mode == MD_INSERT && pos_bad) begin
									res_status_q <= ST_RANGE;
								end else if (req.mode == MD_APPEND || empty) begin
									at_q    <= AW'(cnt_q);
									state_q <= S_FIN;
								end else begin
									at_q    <= (req.mode == MD_PUSH_FRONT) ? '0 : pos_idx;
									idx_q   <= last_idx;
									state_q <= S_UP;
								end
							end
							MD_POP_BACK, MD_POP_FRONT, MD_ERASE: begin
								ins_q <= 1'b0;
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else if (req.mode == MD_ERASE && pos_bad) begin
									res_status_q <= ST_RANGE;
								end else if (req.mode == MD_POP_BACK) begin
									state_q <= S_FIN;
								end else if (req.mode == MD_POP_FRONT) begin
									idx_q   <= AW'(1);
									state_q <= (last_idx == '0) ? S_FIN : S_DN;
								end else begin
									idx_q   <= pos_idx + AW'(1);
									state_q <= (pos_idx == last_idx) ? S_FIN : S_DN;
								end
							end
							MD_FIND: begin
								idx_q <= '0;
								if (!empty)
									state_q <= S_FIND;
							end
							default: begin
							end
						endcase
					end
				end
				// Move entries up one place, from the tail down to the insert point
				S_UP: begin
					wr_s1    <= 1'b1;
					waddr_s1 <= idx_q + AW'(1);
					if (idx_q == at_q)
						state_q <= S_FIN;
					else
						idx_q <= idx_q - AW'(1);
				end
				// Move entries down one place, from past the gap up to the tail
				S_DN: begin
					wr_s1    <= 1'b1;
					waddr_s1 <= idx_q - AW'(1);
					if (idx_q == last_idx)
						state_q <= S_FIN;
					else
						idx_q <= idx_q + AW'(1);
				end
				// Scan entries from the front, comparing each word once its registered read returns
				S_FIND: begin
					if (cmp_s1 && match) begin
						res_found_q <= FOUND_W'(idx_s1);
						state_q     <= S_DONE;
					end else if (cmp_s1 && last_s1) begin
						state_q <= S_DONE;
					end else begin
						cmp_s1  <= 1'b1;
						idx_s1  <= idx_q;
						last_s1 <= (idx_q == last_idx);
						idx_q   <= idx_q + AW'(1);
					end
				end
				// Drain the last move, then place the new word on an insert and update the count
				S_FIN: begin
					if (!wr_s1) begin
						cnt_q   <= ins_q ? cnt_q + CW'(1) : cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				// Hand the result to the output register once it is free
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_count_q  <= COUNT_W'(cnt_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_found_q;
	assign rsp.count       = out_count_q;

	// Count never exceeds the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("list count above capacity");

	// Count moves only when an operation finishes
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_FIN |=> cnt_q == $past(cnt_q))
		else $error("list count changed outside finish");

	// No memory write while waiting for a request or handing off a result
	a_no_idle_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("entry write while idle");

	// An accepted request always leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != S_IDLE)
		else $error("request accepted but engine idle");

	// A shift write occurs only in the shift or finish states
	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == S_UP || state_q == S_DN || state_q == S_FIN))
		else $error("shift write outside shift");

endmodule

`default_nettype wire
